[hdl/sbpd_pkg.sv]
package sbpd_pkg;

  // Frame layout: nine payload bytes followed by one checksum byte.
  localparam int PAYLOAD_LEN = 9;
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] CHECK_POS = 4'd9;

  // Hunt phase codes.
  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PHASE_HUNT = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_WAIT = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_BODY = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd170;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd85;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } sbpd_sync_cfg_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] ball_y;
    logic [15:0] ball_x;
    logic [15:0] goal_x;
    logic [15:0] goal_y;
    logic [7:0]  goal_colour;
  } sbpd_result_t;

endpackage

[hdl/sync_byte_packet_deframer_xor_core.sv]
// Byte-stream deframer: each request on the input channel carries one received
// byte. The block hunts for the two sync bytes set in registers 0 and 1, then
// takes nine payload bytes and a checksum byte, and delivers one result request
// (four big-endian 16-bit coordinates and a colour byte) only when the XOR of
// the payload equals the checksum. It takes one byte per cycle while not
// stalled; a byte passes an input register, the framing logic and an output
// register, which takes the result as the checksum byte leaves the input
// register. A waiting result stalls only bytes that would make a new one.
module sync_byte_packet_deframer_xor_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_ball_y,
  output logic [15:0]                    out_ball_x,
  output logic [15:0]                    out_goal_x,
  output logic [15:0]                    out_goal_y,
  output logic [7:0]                     out_goal_colour,
  input  logic                           cfg_wr_en,
  input  logic [sbpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata
);

  sbpd_pkg::sbpd_sync_cfg_t sync_cfg_r;
  sbpd_pkg::sbpd_result_t   result;
  sbpd_pkg::sbpd_result_t   out_data_r;
  logic                     in_vld_r;
  logic [7:0]               in_byte_r;
  logic                     out_valid_r;
  logic                     out_free;
  logic                     advance;
  logic                     in_accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_cfg_r.first  <= sbpd_pkg::SYNC_FIRST_RST;
      sync_cfg_r.second <= sbpd_pkg::SYNC_SECOND_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sbpd_pkg::REG_SYNC_FIRST:  sync_cfg_r.first  <= cfg_wdata;
        sbpd_pkg::REG_SYNC_SECOND: sync_cfg_r.second <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake control: the held byte moves on unless it makes a result
  // and the output register is still occupied.
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_vld_r && (out_free || !result.hit);
  assign in_stall  = in_vld_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_accept) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_rx_byte;
    end
  end

  sbpd_deframer u_deframer (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .rx_byte  (in_byte_r),
    .sync_cfg (sync_cfg_r),
    .result   (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && result.hit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.hit) begin
      out_data_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ball_y      = out_data_r.ball_y;
  assign out_ball_x      = out_data_r.ball_x;
  assign out_goal_x      = out_data_r.goal_x;
  assign out_goal_y      = out_data_r.goal_y;
  assign out_goal_colour = out_data_r.goal_colour;

  // A new result is only loaded into a free output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result.hit) |-> out_free)
    else $error("result loaded over a pending result");

  // A held result that was stalled stays put until taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result lost or changed");

  // A byte is held back only when it would make a result that cannot be stored.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && result.hit && out_valid_r && out_stall))
    else $error("input stalled without cause");

  // A taken result with nothing new behind it clears the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !(advance && result.hit)) |=> !out_valid_r)
    else $error("delivered result repeated");

endmodule

[hdl/sbpd_deframer.sv]
module sbpd_deframer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [7:0]            rx_byte,
  input  sbpd_pkg::sbpd_sync_cfg_t sync_cfg,
  output sbpd_pkg::sbpd_result_t   result
);

  logic [sbpd_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [sbpd_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]                   xor_r, xor_nxt;
  logic [7:0]                   store_r [sbpd_pkg::PAYLOAD_LEN];
  logic                         store_we;

  // Next-state logic for the sync hunt and body collection.
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    store_we  = 1'b0;
    case (phase_r)
      sbpd_pkg::PHASE_WAIT: begin
        if (rx_byte == sync_cfg.second) begin
          phase_nxt = sbpd_pkg::PHASE_BODY;
          pos_nxt   = '0;
          xor_nxt   = '0;
        end else if (rx_byte != sync_cfg.first) begin
          phase_nxt = sbpd_pkg::PHASE_HUNT;
        end
      end
      sbpd_pkg::PHASE_BODY: begin
        if (pos_r < sbpd_pkg::CHECK_POS) begin
          store_we = 1'b1;
          xor_nxt  = xor_r ^ rx_byte;
          pos_nxt  = pos_r + 4'd1;
        end else begin
          phase_nxt = sbpd_pkg::PHASE_HUNT;
          pos_nxt   = '0;
        end
      end
      default: begin
        // Hunting, and the unused phase code behaves the same way.
        phase_nxt = (rx_byte == sync_cfg.first) ? sbpd_pkg::PHASE_WAIT
                                                : sbpd_pkg::PHASE_HUNT;
      end
    endcase
  end

  // A result comes out on the checksum byte when it matches the running XOR.
  always_comb begin
    result.hit = (phase_r == sbpd_pkg::PHASE_BODY) && (pos_r == sbpd_pkg::CHECK_POS) &&
                 (xor_r == rx_byte);
    result.ball_y      = {store_r[0], store_r[1]};
    result.ball_x      = {store_r[2], store_r[3]};
    result.goal_x      = {store_r[4], store_r[5]};
    result.goal_y      = {store_r[6], store_r[7]};
    result.goal_colour = store_r[8];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sbpd_pkg::PHASE_HUNT;
      pos_r   <= '0;
      xor_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
    end
  end

  // Payload bytes, written in order at the current body position.
  always_ff @(posedge clk) begin
    if (advance && store_we) begin
      store_r[pos_r] <= rx_byte;
    end
  end

endmodule
